FILE: hdl/cia_pkg.sv
// complex integer alu: shared types and constants
// no dependencies
`default_nettype none
package cia_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned ResWidth        = 33;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // per-request side information carried along the divider
  typedef struct packed {
    logic neg_re;
    logic neg_im;
    logic dz;
  } side_t;

endpackage
`default_nettype wire

FILE: hdl/cia_divider.sv
// complex integer alu: pipelined restoring divider, one quotient bit per stage,
// two numerators sharing one divisor; depends on cia_pkg
`default_nettype none
module cia_divider import cia_pkg::*; #(
  parameter int unsigned N = 33
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire logic [N-1:0] num_re_i,
  input  wire logic [N-1:0] num_im_i,
  input  wire logic [N-1:0] den_i,
  input  wire side_t        side_i,
  output logic              valid_o,
  output logic [N-1:0]      quo_re_o,
  output logic [N-1:0]      quo_im_o,
  output side_t             side_o
);

  logic         vld_q  [N+1];
  logic [N-1:0] qre_q  [N+1];
  logic [N-1:0] qim_q  [N+1];
  logic [N-1:0] rre_q  [N+1];
  logic [N-1:0] rim_q  [N+1];
  logic [N-1:0] den_q  [N+1];
  side_t        side_q [N+1];

  assign vld_q[0]  = valid_i;
  assign qre_q[0]  = num_re_i;
  assign qim_q[0]  = num_im_i;
  assign rre_q[0]  = '0;
  assign rim_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar i = 1; i <= N; i++) begin : g_stage
    logic [N:0]   sre, sim;
    logic [N+1:0] dre, dim;
    logic [N-1:0] rre_d, rim_d;
    logic         bre, bim;

    always_comb begin
      sre = {rre_q[i-1], qre_q[i-1][N-1]};
      sim = {rim_q[i-1], qim_q[i-1][N-1]};
      dre = {1'b0, sre} - {2'b00, den_q[i-1]};
      dim = {1'b0, sim} - {2'b00, den_q[i-1]};
      bre = ~dre[N+1];
      bim = ~dim[N+1];
      // remainder stays below the divisor, so the low bits suffice
      rre_d = bre ? dre[N-1:0] : sre[N-1:0];
      rim_d = bim ? dim[N-1:0] : sim[N-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rre_q[i]  <= rre_d;
      rim_q[i]  <= rim_d;
      den_q[i]  <= den_q[i-1];
      side_q[i] <= side_q[i-1];
      if (N > 1) begin
        qre_q[i] <= {qre_q[i-1][N-2:0], bre};
        qim_q[i] <= {qim_q[i-1][N-2:0], bim};
      end else begin
        qre_q[i] <= N'(bre);
        qim_q[i] <= N'(bim);
      end
    end
  end

  assign valid_o  = vld_q[N];
  assign quo_re_o = qre_q[N];
  assign quo_im_o = qim_q[N];
  assign side_o   = side_q[N];

endmodule
`default_nettype wire

FILE: hdl/complex_integer_alu.sv
// complex integer alu: add, subtract, multiply and divide of complex integers
// stages a, b and c, the bit-per-stage divider and the output register in turn; one request
// per cycle, busy is never raised; results are strobed for one cycle
// reset clears the valid bits of every stage; depends on cia_pkg, cia_divider
`default_nettype none
module complex_integer_alu import cia_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_real_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_imag_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_real_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_imag_i,
  output logic                                 res_valid_o,
  output logic signed [ResWidth-1:0]           res_real_o,
  output logic signed [ResWidth-1:0]           res_imag_o,
  output logic                                 div_by_zero_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned N  = 2 * W + 1;
  localparam int unsigned EW = (N > ResWidth + 1) ? N : ResWidth + 1;
  localparam logic [EW-1:0] PosMax = EW'((64'd1 << (ResWidth - 1)) - 64'd1);
  localparam logic [EW-1:0] NegMax = EW'(64'd1 << (ResWidth - 1));

  assign busy = 1'b0;

  // stage a: products and plain sums
  logic                 va_q;
  op_e                  opa_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, s_rr_q, s_ii_q;
  logic signed [W:0]    sum_re_q, sum_im_q;
  logic signed [W:0]    sum_re_d, sum_im_d;

  always_comb begin
    if (op_e'(req_type_i) == OP_SUB) begin
      sum_re_d = (W+1)'(a_real_i) - (W+1)'(b_real_i);
      sum_im_d = (W+1)'(a_imag_i) - (W+1)'(b_imag_i);
    end else begin
      sum_re_d = (W+1)'(a_real_i) + (W+1)'(b_real_i);
      sum_im_d = (W+1)'(a_imag_i) + (W+1)'(b_imag_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q    <= op_e'(req_type_i);
    p_rr_q   <= PW'(a_real_i) * PW'(b_real_i);
    p_ii_q   <= PW'(a_imag_i) * PW'(b_imag_i);
    p_ri_q   <= PW'(a_real_i) * PW'(b_imag_i);
    p_ir_q   <= PW'(a_imag_i) * PW'(b_real_i);
    s_rr_q   <= PW'(b_real_i) * PW'(b_real_i);
    s_ii_q   <= PW'(b_imag_i) * PW'(b_imag_i);
    sum_re_q <= sum_re_d;
    sum_im_q <= sum_im_d;
  end

  // stage b: combine products, divisor magnitude
  logic                vb_q;
  op_e                 opb_q;
  logic signed [N-1:0] valb_re_q, valb_im_q, valb_re_d, valb_im_d;
  logic        [N-1:0] denb_q, denb_d;
  logic signed [N-1:0] x_rr, x_ii, x_ri, x_ir;

  always_comb begin
    x_rr   = N'(p_rr_q);
    x_ii   = N'(p_ii_q);
    x_ri   = N'(p_ri_q);
    x_ir   = N'(p_ir_q);
    denb_d = N'(1);
    case (opa_q)
      OP_ADD, OP_SUB: begin
        valb_re_d = N'(sum_re_q);
        valb_im_d = N'(sum_im_q);
      end
      OP_MUL: begin
        valb_re_d = x_rr - x_ii;
        valb_im_d = x_ri + x_ir;
      end
      OP_DIV: begin
        valb_re_d = x_rr + x_ii;
        valb_im_d = x_ir - x_ri;
        // squares are never negative
        denb_d    = {1'b0, s_rr_q[PW-1:0]} + {1'b0, s_ii_q[PW-1:0]};
      end
      default: begin
        valb_re_d = '0;
        valb_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    opb_q     <= opa_q;
    valb_re_q <= valb_re_d;
    valb_im_q <= valb_im_d;
    denb_q    <= denb_d;
  end

  // stage c: sign and magnitude
  logic         vc_q;
  logic [N-1:0] magc_re_q, magc_im_q, denc_q;
  side_t        sidec_q, sidec_d;

  always_comb begin
    sidec_d.neg_re = valb_re_q[N-1];
    sidec_d.neg_im = valb_im_q[N-1];
    sidec_d.dz     = (opb_q == OP_DIV) && (denb_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    magc_re_q <= valb_re_q[N-1] ? N'(-valb_re_q) : N'(valb_re_q);
    magc_im_q <= valb_im_q[N-1] ? N'(-valb_im_q) : N'(valb_im_q);
    denc_q    <= denb_q;
    sidec_q   <= sidec_d;
  end

  logic         vd;
  logic [N-1:0] quo_re, quo_im;
  side_t        sided;

  cia_divider #(
    .N(N)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vc_q),
    .num_re_i (magc_re_q),
    .num_im_i (magc_im_q),
    .den_i    (denc_q),
    .side_i   (sidec_q),
    .valid_o  (vd),
    .quo_re_o (quo_re),
    .quo_im_o (quo_im),
    .side_o   (sided)
  );

  // output stage: saturate, apply sign, zero both parts on divide by zero
  logic [EW-1:0] mre, mim, sre, sim;
  logic [EW-1:0] ore, oim;

  always_comb begin
    mre = EW'(quo_re);
    mim = EW'(quo_im);
    if (sided.neg_re) begin
      sre = (mre > NegMax) ? NegMax : mre;
      ore = -sre;
    end else begin
      sre = (mre > PosMax) ? PosMax : mre;
      ore = sre;
    end
    if (sided.neg_im) begin
      sim = (mim > NegMax) ? NegMax : mim;
      oim = -sim;
    end else begin
      sim = (mim > PosMax) ? PosMax : mim;
      oim = sim;
    end
    if (sided.dz) begin
      ore = '0;
      oim = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    res_real_o    <= ore[ResWidth-1:0];
    res_imag_o    <= oim[ResWidth-1:0];
    div_by_zero_o <= sided.dz;
  end

endmodule
`default_nettype wire
